// ----- src/z85_pkg.sv -----
// z85_pkg: shared types, constants and the Z85 alphabet lookup for the
// byte stream encoder. No dependencies; every other file in src uses it.

package z85_pkg;

  // Default depth of the job queue between front and back
  localparam int JOB_DEPTH = 4;

  // Reciprocal of 85 for a 32-bit dividend: q = (w * DIV85_MAGIC) >> DIV85_SHIFT
  localparam logic [31:0] DIV85_MAGIC = 32'hC0C0C0C1;
  localparam int          DIV85_SHIFT = 38;

  // Number of divide-by-85 passes per word and characters per group
  localparam int DIVS_PER_WORD   = 4;
  localparam int CHARS_PER_GROUP = 5;

  // Highest base-85 digit
  localparam int DIGIT_MAX = 84;

  // Alphabet, first character in the top byte
  localparam logic [85*8-1:0] ALPHABET =
    "0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ.-:+=^!/*?&<>()[]{}@%$#";

  // One input item
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } z85_in_t;

  // One result item
  typedef struct packed {
    logic [6:0] out_char;
    logic       group_end;
    logic       message_end;
    logic       length_error;
  } z85_out_t;

  // Work handed from front to back: a full word, or a length error marker
  typedef struct packed {
    logic [31:0] word;
    logic        last;
    logic        err;
  } z85_job_t;

  // Map a base-85 digit to its ASCII code
  function automatic logic [6:0] z85_char(input logic [6:0] digit);
    logic [9:0] bit_pos;
    bit_pos = {7'(DIGIT_MAX - int'(digit)), 3'b000};
    return ALPHABET[bit_pos +: 7];
  endfunction

endpackage

// ----- src/z85_front.sv -----
// z85_front: accepts input bytes, gathers them into big-endian words and
// classifies each message end. Depends on z85_pkg.

module z85_front (
  input  logic              clk,
  input  logic              rst_n,
  input  z85_pkg::z85_in_t  in_data,
  input  logic              in_push,
  output logic              in_full,
  input  logic              q_full,
  output logic              q_wr_en,
  output z85_pkg::z85_job_t q_wr_data
);

  logic [23:0] acc_r, acc_nxt;
  logic [1:0]  pos_r, pos_nxt;
  logic        accept;

  // Stall input while the job queue has no room
  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  // Gather bytes; issue a word job on the fourth byte or an error job on a short end
  always_comb begin
    acc_nxt        = acc_r;
    pos_nxt        = pos_r;
    q_wr_en        = 1'b0;
    q_wr_data.word = {acc_r, in_data.data_byte};
    q_wr_data.last = in_data.last_byte;
    q_wr_data.err  = 1'b0;
    if (accept) begin
      if (pos_r != 2'd3) begin
        if (in_data.last_byte) begin
          q_wr_en       = 1'b1;
          q_wr_data.err = 1'b1;
          acc_nxt       = '0;
          pos_nxt       = '0;
        end else begin
          acc_nxt = {acc_r[15:0], in_data.data_byte};
          pos_nxt = pos_r + 2'd1;
        end
      end else begin
        q_wr_en = 1'b1;
        acc_nxt = '0;
        pos_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      pos_r <= '0;
    end else begin
      acc_r <= acc_nxt;
      pos_r <= pos_nxt;
    end
  end

endmodule

// ----- src/z85_job_queue.sv -----
// z85_job_queue: small first-in first-out queue of jobs between the front
// and the back. Depends on z85_pkg.

module z85_job_queue #(
  parameter int DEPTH = z85_pkg::JOB_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  z85_pkg::z85_job_t wr_data,
  output logic              full,
  input  logic              rd_en,
  output z85_pkg::z85_job_t rd_data,
  output logic              empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  z85_pkg::z85_job_t mem [DEPTH];

  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr_r];

  // Advance pointers with wrap and track fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    case ({do_wr, do_rd})
      2'b10:   count_nxt = count_r + CNT_W'(1);
      2'b01:   count_nxt = count_r - CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the incoming job
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ----- src/z85_back.sv -----
// z85_back: converts each job into base-85 digits with a shared
// divide-by-85 unit, then emits characters through an output register.
// Depends on z85_pkg.

module z85_back (
  input  logic              clk,
  input  logic              rst_n,
  input  z85_pkg::z85_job_t job_data,
  input  logic              job_empty,
  output logic              job_pop,
  output z85_pkg::z85_out_t out_data,
  output logic              out_empty,
  input  logic              out_pop
);

  // Converter states
  localparam logic [1:0] CV_IDLE = 2'd0;
  localparam logic [1:0] CV_MUL  = 2'd1;
  localparam logic [1:0] CV_REM  = 2'd2;
  localparam logic [1:0] CV_DONE = 2'd3;

  localparam int QUO_W = 64 - z85_pkg::DIV85_SHIFT;

  // Converter registers
  logic [1:0]       cv_state_r, cv_state_nxt;
  logic [31:0]      w_r, w_nxt;
  logic [QUO_W-1:0] quo_r, quo_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic [6:0]       dig_r [z85_pkg::DIVS_PER_WORD];
  logic [6:0]       dig_nxt [z85_pkg::DIVS_PER_WORD];
  logic             cv_last_r, cv_last_nxt;
  logic             cv_err_r, cv_err_nxt;

  // Emitter registers
  logic             em_busy_r, em_busy_nxt;
  logic [2:0]       em_idx_r, em_idx_nxt;
  logic [6:0]       hold_r [z85_pkg::CHARS_PER_GROUP];
  logic [6:0]       hold_nxt [z85_pkg::CHARS_PER_GROUP];
  logic             em_last_r, em_last_nxt;
  logic             em_err_r, em_err_nxt;

  // Output register
  logic              out_valid_r, out_valid_nxt;
  z85_pkg::z85_out_t out_r, out_nxt;

  logic [63:0]      mul_full;
  logic [31:0]      quo_x85;
  logic [31:0]      rem_full;
  logic             handoff;
  logic             out_free;

  // Reciprocal product and remainder of the current quotient
  assign mul_full = {32'b0, w_r} * {32'b0, z85_pkg::DIV85_MAGIC};
  assign quo_x85  = {quo_r, 6'b0} + {2'b0, quo_r, 4'b0} + {4'b0, quo_r, 2'b0}
                  + {6'b0, quo_r};
  assign rem_full = w_r - quo_x85;

  assign out_free  = !out_valid_r || out_pop;
  assign out_empty = !out_valid_r;
  assign out_data  = out_r;

  // Step the converter: load a job, four divisions (none for an error job), then hand digits over
  always_comb begin
    cv_state_nxt = cv_state_r;
    w_nxt        = w_r;
    quo_nxt      = quo_r;
    cnt_nxt      = cnt_r;
    cv_last_nxt  = cv_last_r;
    cv_err_nxt   = cv_err_r;
    dig_nxt      = dig_r;
    job_pop      = 1'b0;
    handoff      = 1'b0;
    unique case (cv_state_r)
      CV_IDLE: begin
        if (!job_empty) begin
          job_pop      = 1'b1;
          w_nxt        = job_data.word;
          cv_last_nxt  = job_data.last;
          cv_err_nxt   = job_data.err;
          cnt_nxt      = '0;
          cv_state_nxt = job_data.err ? CV_DONE : CV_MUL;
        end
      end
      CV_MUL: begin
        quo_nxt      = mul_full[63:z85_pkg::DIV85_SHIFT];
        cv_state_nxt = CV_REM;
      end
      CV_REM: begin
        dig_nxt[cnt_r] = rem_full[6:0];
        w_nxt          = 32'(quo_r);
        if (cnt_r == 2'(z85_pkg::DIVS_PER_WORD - 1)) begin
          cv_state_nxt = CV_DONE;
        end else begin
          cnt_nxt      = cnt_r + 2'd1;
          cv_state_nxt = CV_MUL;
        end
      end
      CV_DONE: begin
        if (!em_busy_r) begin
          handoff = 1'b1;
          if (!job_empty) begin
            job_pop      = 1'b1;
            w_nxt        = job_data.word;
            cv_last_nxt  = job_data.last;
            cv_err_nxt   = job_data.err;
            cnt_nxt      = '0;
            cv_state_nxt = job_data.err ? CV_DONE : CV_MUL;
          end else begin
            cv_state_nxt = CV_IDLE;
          end
        end
      end
      default: cv_state_nxt = CV_IDLE;
    endcase
  end

  // Take finished digits and emit one character per free output slot
  always_comb begin
    em_busy_nxt   = em_busy_r;
    em_idx_nxt    = em_idx_r;
    hold_nxt      = hold_r;
    em_last_nxt   = em_last_r;
    em_err_nxt    = em_err_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_pop;
    if (handoff) begin
      em_busy_nxt = 1'b1;
      em_idx_nxt  = 3'(z85_pkg::CHARS_PER_GROUP - 1);
      em_last_nxt = cv_last_r;
      em_err_nxt  = cv_err_r;
      for (int i = 0; i < z85_pkg::DIVS_PER_WORD; i++) begin
        hold_nxt[i] = dig_r[i];
      end
      hold_nxt[z85_pkg::CHARS_PER_GROUP - 1] = w_r[6:0];
    end else if (em_busy_r && out_free) begin
      out_valid_nxt = 1'b1;
      if (em_err_r) begin
        out_nxt.out_char     = '0;
        out_nxt.group_end    = 1'b0;
        out_nxt.message_end  = 1'b1;
        out_nxt.length_error = 1'b1;
        em_busy_nxt          = 1'b0;
      end else begin
        out_nxt.out_char     = z85_pkg::z85_char(hold_r[em_idx_r]);
        out_nxt.group_end    = (em_idx_r == '0);
        out_nxt.message_end  = (em_idx_r == '0) && em_last_r;
        out_nxt.length_error = 1'b0;
        if (em_idx_r == '0) begin
          em_busy_nxt = 1'b0;
        end else begin
          em_idx_nxt = em_idx_r - 3'd1;
        end
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_state_r  <= CV_IDLE;
      em_busy_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cv_state_r  <= cv_state_nxt;
      em_busy_r   <= em_busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    w_r       <= w_nxt;
    quo_r     <= quo_nxt;
    cnt_r     <= cnt_nxt;
    cv_last_r <= cv_last_nxt;
    cv_err_r  <= cv_err_nxt;
    dig_r     <= dig_nxt;
    em_idx_r  <= em_idx_nxt;
    hold_r    <= hold_nxt;
    em_last_r <= em_last_nxt;
    em_err_r  <= em_err_nxt;
    out_r     <= out_nxt;
  end

endmodule

// ----- src/z85_byte_stream_encoder_unit.sv -----
// z85_byte_stream_encoder_unit: top level of the Z85 byte stream encoder.
// Depends on z85_pkg, z85_front, z85_job_queue and z85_back.
//
// Bytes are pushed in with a last-of-message flag; every four bytes become
// five Z85 characters on the result queue, most significant digit first,
// with group_end on the fifth and message_end on the final result of a
// message. A message whose length is not a multiple of four ends in one
// result with length_error and message_end set and out_char zero; its
// partial bytes are dropped. Bytes are taken one per cycle while the job
// queue (JOB_DEPTH entries) has room. The back end converts a word in
// four divide-by-85 passes, each a multiply step and a remainder step
// through one shared reciprocal multiplier, then hands the digits to the
// emitter; an error job skips the passes. The five characters of a group
// leave one per cycle from the output register while the receiver pops
// each one, and the next word is converted meanwhile.

module z85_byte_stream_encoder_unit #(
  parameter int JOB_DEPTH = z85_pkg::JOB_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  z85_pkg::z85_in_t  in_data,
  input  logic              in_push,
  output logic              in_full,
  output z85_pkg::z85_out_t out_data,
  output logic              out_empty,
  input  logic              out_pop
);

  logic              q_full;
  logic              q_wr_en;
  z85_pkg::z85_job_t q_wr_data;
  logic              q_rd_en;
  z85_pkg::z85_job_t q_rd_data;
  logic              q_empty;

  // Accept and classify bytes
  z85_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .in_push   (in_push),
    .in_full   (in_full),
    .q_full    (q_full),
    .q_wr_en   (q_wr_en),
    .q_wr_data (q_wr_data)
  );

  // Decouple front and back
  z85_job_queue #(
    .DEPTH (JOB_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr_en),
    .wr_data (q_wr_data),
    .full    (q_full),
    .rd_en   (q_rd_en),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  // Convert words and emit characters
  z85_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_data  (q_rd_data),
    .job_empty (q_empty),
    .job_pop   (q_rd_en),
    .out_data  (out_data),
    .out_empty (out_empty),
    .out_pop   (out_pop)
  );

endmodule

// ----- src/z85_checker.sv -----
// z85_checker: port-level assertions for the Z85 encoder top level, and the
// bind that attaches them. Depends on z85_pkg and z85_byte_stream_encoder_unit.

module z85_checker (
  input logic              clk,
  input logic              rst_n,
  input z85_pkg::z85_in_t  in_data,
  input logic              in_push,
  input logic              in_full,
  input z85_pkg::z85_out_t out_data,
  input logic              out_empty,
  input logic              out_pop
);

  // Hold a waiting result until it is taken
  assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data)))
    else $error("waiting result changed or vanished");

  // Drop all results and open the input on reset
  assert property (@(posedge clk) !rst_n |=> (out_empty && !in_full))
    else $error("queues not cleared after reset");

  // Accepted items carry known bits
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full) |-> !$isunknown(in_data))
    else $error("accepted item has unknown bits");

  // Error results carry no character and close the message
  assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.length_error) |->
      (out_data.out_char == 7'd0 && out_data.message_end && !out_data.group_end))
    else $error("malformed length error result");

  // Normal results carry a printable alphabet character and set message_end only with group_end
  assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_data.length_error) |->
      (out_data.out_char >= 7'd33 && out_data.out_char <= 7'd125 &&
       (!out_data.message_end || out_data.group_end)))
    else $error("character result out of range or misflagged");

endmodule

bind z85_byte_stream_encoder_unit z85_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_data   (in_data),
  .in_push   (in_push),
  .in_full   (in_full),
  .out_data  (out_data),
  .out_empty (out_empty),
  .out_pop   (out_pop)
);

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// tb_top: self-checking bench for z85_byte_stream_encoder_unit.
// Depends on z85_pkg and the encoder RTL; an in-bench encoder model predicts
// every character, and each popped result is checked against the oldest one.

module tb_top;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_GAP      = 16;

  // Z85 digit characters, digit 0 in the top byte
  localparam logic [85*8-1:0] DIGIT_CHARS =
    "0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ.-:+=^!/*?&<>()[]{}@%$#";

  logic              clk = 1'b0;
  logic              rst_n;
  z85_pkg::z85_in_t  in_data;
  logic              in_push;
  logic              in_full;
  z85_pkg::z85_out_t out_data;
  logic              out_empty;
  logic              out_pop;

  // Predicted characters, oldest first, and the model's group state
  z85_pkg::z85_out_t expected_chars[$];
  logic [23:0]       group_bytes = '0;
  logic [1:0]        group_count = '0;

  int                error_count = 0;
  int                bytes_sent  = 0;
  int                cycle_count = 0;
  bit                in_no_idle  = 1'b0;
  bit                out_no_idle = 1'b0;
  z85_pkg::z85_out_t want;

  z85_byte_stream_encoder_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .in_push  (in_push),
    .in_full  (in_full),
    .out_data (out_data),
    .out_empty(out_empty),
    .out_pop  (out_pop)
  );

  always #10 clk = ~clk;

  // Draw the idle cycles before one item
  function automatic int draw_gap(input bit no_idle);
    if (no_idle) begin
      return 0;
    end
    return $urandom_range(0, MAX_GAP);
  endfunction

  function automatic logic [6:0] digit_char(input int unsigned digit);
    logic [7:0] code;
    code = DIGIT_CHARS[(84 - digit) * 8 +: 8];
    return code[6:0];
  endfunction

  // Advance the encoder model by one byte and queue the characters it causes
  task automatic predict_encoding(input z85_pkg::z85_in_t item);
    z85_pkg::z85_out_t res;
    logic [31:0]       word;
    int unsigned       rest;
    logic [6:0]        digits[5];
    int                k;
    if (group_count < 2'd3) begin
      if (item.last_byte) begin
        // short message: one error marker, partial bytes dropped
        res.out_char     = '0;
        res.group_end    = 1'b0;
        res.message_end  = 1'b1;
        res.length_error = 1'b1;
        expected_chars.push_back(res);
        group_bytes = '0;
        group_count = '0;
      end else begin
        group_bytes = {group_bytes[15:0], item.data_byte};
        group_count = group_count + 2'd1;
      end
    end else begin
      word = {group_bytes, item.data_byte};
      rest = word;
      for (k = 4; k >= 0; k--) begin
        digits[k] = digit_char(rest % 85);
        rest      = rest / 85;
      end
      for (k = 0; k < 5; k++) begin
        res.out_char     = digits[k];
        res.group_end    = (k == 4);
        res.message_end  = (k == 4) && item.last_byte;
        res.length_error = 1'b0;
        expected_chars.push_back(res);
      end
      group_bytes = '0;
      group_count = '0;
    end
  endtask

  // Predict on every accepted input item
  always @(posedge clk) begin
    if (rst_n && in_push && !in_full) begin
      predict_encoding(in_data);
    end
  end

  // Compare every accepted result with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected result: out_char %0d group_end %0d message_end %0d length_error %0d",
               out_data.out_char, out_data.group_end, out_data.message_end,
               out_data.length_error);
        error_count++;
      end else begin
        want = expected_chars.pop_front();
        if (out_data.out_char !== want.out_char) begin
          $error("out_char: expected %0d, actual %0d", want.out_char, out_data.out_char);
          error_count++;
        end
        if (out_data.group_end !== want.group_end) begin
          $error("group_end: expected %0d, actual %0d", want.group_end, out_data.group_end);
          error_count++;
        end
        if (out_data.message_end !== want.message_end) begin
          $error("message_end: expected %0d, actual %0d",
                 want.message_end, out_data.message_end);
          error_count++;
        end
        if (out_data.length_error !== want.length_error) begin
          $error("length_error: expected %0d, actual %0d",
                 want.length_error, out_data.length_error);
          error_count++;
        end
      end
    end
  end

  // Pop results with a random stall before each one
  initial begin : pop_results
    int stall;
    out_pop = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = draw_gap(out_no_idle);
      if (stall > 0) begin
        @(negedge clk);
        out_pop <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty);
    end
  end

  // Stop the run if it hangs
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // Send one byte; hold it until the encoder takes it
  task automatic send_byte(input logic [7:0] value, input logic is_last);
    int               gap;
    z85_pkg::z85_in_t item;
    gap            = draw_gap(in_no_idle);
    item.data_byte = value;
    item.last_byte = is_last;
    if (gap > 0) begin
      @(negedge clk);
      in_push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_data <= item;
    in_push <= 1'b1;
    do @(posedge clk); while (in_full);
    bytes_sent++;
  endtask

  // Send a message of random bytes, last flag on the final one
  task automatic send_message(input int len);
    int i;
    for (i = 0; i < len; i++) begin
      send_byte(8'($urandom_range(0, 255)), i == len - 1);
    end
  endtask

  // Drop push and hold off until every predicted result has been popped
  task automatic wait_for_results();
    @(negedge clk);
    in_push <= 1'b0;
    while (expected_chars.size() != 0) @(negedge clk);
  endtask

  task automatic test_zero_word();
    repeat (4) send_byte(8'h00, 1'b0);
    wait_for_results();
  endtask

  // All-ones word, the largest input word, as a one-group message
  task automatic test_max_word();
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    wait_for_results();
  endtask

  // Two-group message; message_end only on the second group
  task automatic test_known_text();
    send_byte(8'h86, 1'b0);
    send_byte(8'h4F, 1'b0);
    send_byte(8'hD2, 1'b0);
    send_byte(8'h6F, 1'b0);
    send_byte(8'hB5, 1'b0);
    send_byte(8'h59, 1'b0);
    send_byte(8'hF7, 1'b0);
    send_byte(8'h5B, 1'b1);
    wait_for_results();
  endtask

  // Messages that end after one, two and three bytes of a group
  task automatic test_short_messages();
    send_message(1);
    send_message(2);
    send_message(3);
    wait_for_results();
  endtask

  // Mostly whole-group messages, some with a ragged end
  task automatic test_random_messages(input int count);
    int start;
    int len;
    start = bytes_sent;
    while (bytes_sent - start < count) begin
      if ($urandom_range(0, 3) != 0) begin
        send_message(4 * $urandom_range(1, 4));
      end else begin
        len = $urandom_range(1, 15);
        if (len % 4 == 0) begin
          len++;
        end
        send_message(len);
      end
    end
    wait_for_results();
  endtask

  // Random last flags anywhere in the stream
  task automatic test_random_noise(input int count);
    repeat (count) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
    wait_for_results();
  endtask

  // No idling on either side
  task automatic test_back_to_back(input int count);
    in_no_idle  = 1'b1;
    out_no_idle = 1'b1;
    test_random_messages(count);
    in_no_idle  = 1'b0;
    out_no_idle = 1'b0;
  endtask

  // Sender never idles while the receiver stalls, so the queue fills up
  task automatic test_full_queue(input int count);
    in_no_idle = 1'b1;
    test_random_messages(count);
    in_no_idle = 1'b0;
  endtask

  initial begin
    rst_n   = 1'b0;
    in_push = 1'b0;
    in_data = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_zero_word();
    test_max_word();
    test_known_text();
    test_short_messages();
    test_random_messages(100);
    test_back_to_back(40);
    test_full_queue(40);
    test_random_noise(30);
    test_random_messages(30);

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
